[rtl/tci_pkg.sv]
`default_nettype none
package tci_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int NUM_COEF    = 9;
    localparam int COEF_W      = $clog2(NUM_COEF);
    localparam int NUM_ANGLE   = 3;
    localparam logic [31:0] DEG2RAD_Q32 = 32'd74961321;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_BEFORE = 2'd0;
    localparam logic [1:0] ST_AFTER  = 2'd1;
    localparam logic [1:0] ST_INTERP = 2'd2;

    typedef struct packed {
        logic               op;
        logic [9:0]         entry_index;
        logic [31:0]        stamp;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] angle_xy;
        logic signed [31:0] angle_xz;
        logic signed [31:0] angle_yz;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_scale_x;
        logic signed [31:0] out_scale_y;
        logic signed [31:0] out_scale_z;
        logic signed [31:0] out_offset_x;
        logic signed [31:0] out_offset_y;
        logic signed [31:0] out_offset_z;
        logic signed [31:0] out_angle_xy;
        logic signed [31:0] out_angle_xz;
        logic signed [31:0] out_angle_yz;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [32:0] mag;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quo;
    } div_rsp_t;

endpackage
`default_nettype wire

[rtl/tci_divider.sv]
`default_nettype none
// Unsigned (mag * num) / den, restoring long division one quotient bit a cycle.
module tci_divider
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tci_pkg::div_req_t req,
    output tci_pkg::div_rsp_t      rsp
);
    localparam int PW = 65;
    localparam int CW = $clog2(PW + 1);

    logic [PW-1:0] dvd_reg;
    logic [32:0]   rem_reg;
    logic [31:0]   den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [33:0]   trial;
    logic          fits;

    assign trial = {rem_reg, dvd_reg[PW-1]};
    assign fits  = trial >= {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(PW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.mag * req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            // Shift one dividend bit in; quotient bits fill dvd from the bottom.
            rem_reg <= fits ? 33'(trial - {2'b00, den_reg}) : trial[32:0];
            dvd_reg <= {dvd_reg[PW-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = dvd_reg[32:0];
endmodule
`default_nettype wire

[rtl/timed_calibration_interpolator_core.sv]
`default_nettype none
// Calibration table with time lookup and linear interpolation.
// in channel (in_valid/in_ready/in_data): op LOAD writes one table slot (time plus
// nine Q16.16 values) and gives no result; op QUERY returns one out_data beat
// with the status and nine values, angles converted to radians.
// cfg_we/cfg_data set entries_in_use (0 acts as 1, above 1024 as 1024);
// write it only while idle.
// A load makes one memory write per coefficient in S_LOAD, the time with the first.
// A query runs bound checks on the first and last time, about 10 search steps
// on a full table, a fetch of the bracketing times, then per coefficient
// 2 reads, one division in the shared divider and an angle multiply; the end
// cases skip the division and the search.
// One item at a time: in_ready is low from acceptance until the load ends or
// the result beat is taken, so a stalled receiver holds the block.
// Reset clears control and sets entries_in_use to 1. Table contents are
// undefined until loaded; no clearing pass.
module timed_calibration_interpolator_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tci_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tci_pkg::out_item_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic [10:0]        cfg_data
);
    localparam int IW = tci_pkg::IDX_W;
    localparam int CW = tci_pkg::COEF_W;
    localparam int CAW = $clog2(tci_pkg::TABLE_DEPTH * tci_pkg::NUM_COEF);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_T0, S_TN, S_SPAN, S_MID, S_CMP, S_T1,
        S_RD0, S_RD1, S_DIV, S_WAITD, S_ANG, S_NEXT, S_OUT
    } state_t;

    state_t state_reg;
    logic [10:0] cfg_reg;
    tci_pkg::in_item_t item_reg;
    logic [IW-1:0] lo_reg, hi_reg, last_reg;
    logic [CW-1:0] k_reg;
    logic [1:0] status_reg;
    logic [31:0] x0_reg, span_reg;
    logic signed [31:0] v0_reg;
    logic signed [31:0] vals_reg [tci_pkg::NUM_COEF];
    logic neg_reg;
    logic [63:0] prod_reg;

    logic [31:0] tmem [tci_pkg::TABLE_DEPTH];
    logic [31:0] cmem [tci_pkg::TABLE_DEPTH * tci_pkg::NUM_COEF];
    logic [31:0] trd_reg, crd_reg;
    logic [IW-1:0] taddr;
    logic [CAW-1:0] caddr;
    logic [IW-1:0] row;
    logic [IW-1:0] mid;

    tci_pkg::div_req_t dreq;
    tci_pkg::div_rsp_t drsp;

    logic [10:0] n_eff;
    assign n_eff = (cfg_reg == 11'd0) ? 11'd1 :
                   (cfg_reg > 11'(tci_pkg::TABLE_DEPTH)) ? 11'(tci_pkg::TABLE_DEPTH) : cfg_reg;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  taddr = '0;
            S_T0:    taddr = last_reg;
            S_MID:   taddr = mid;
            S_T1:    taddr = lo_reg;
            default: taddr = hi_reg;
        endcase
        case (state_reg)
            S_RD0:   row = lo_reg;
            default: row = (status_reg == tci_pkg::ST_INTERP) ? hi_reg : lo_reg;
        endcase
        caddr = CAW'(row) * CAW'(tci_pkg::NUM_COEF) + CAW'(k_reg);
    end

    always_ff @(posedge clk)
    begin
        trd_reg <= tmem[taddr];
        crd_reg <= cmem[caddr];
        if (state_reg == S_LOAD && k_reg == '0)
            tmem[item_reg.entry_index[IW-1:0]] <= item_reg.stamp;
        if (state_reg == S_LOAD)
            cmem[CAW'(item_reg.entry_index[IW-1:0]) * CAW'(tci_pkg::NUM_COEF) + CAW'(k_reg)]
                <= item_reg[32*(tci_pkg::NUM_COEF-1-int'(k_reg)) +: 32];
    end

    logic signed [32:0] diff;
    assign diff = 33'(signed'(crd_reg)) - 33'(v0_reg);

    always_comb
    begin
        dreq.start = (state_reg == S_DIV);
        dreq.mag   = diff[32] ? 33'(-diff) : diff;
        dreq.num   = item_reg.stamp - x0_reg;
        dreq.den   = span_reg;
    end

    tci_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [31:0] amag;
    logic [31:0] rad;
    assign amag = vals_reg[k_reg][31] ? 32'(-vals_reg[k_reg]) : vals_reg[k_reg];
    assign rad  = 32'((prod_reg + 64'h8000_0000) >> 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cfg_reg   <= 11'd1;
            in_ready  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    in_ready <= 1'b1;
                    if (in_valid && in_ready)
                    begin
                        in_ready <= 1'b0;
                        item_reg <= in_data;
                        k_reg    <= '0;
                        last_reg <= IW'(n_eff - 11'd1);
                        state_reg <= (in_data.op == tci_pkg::OP_LOAD) ? S_LOAD : S_T0;
                    end
                end
                S_LOAD:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == CW'(tci_pkg::NUM_COEF - 1))
                        state_reg <= S_IDLE;
                end
                S_T0: // trd = t[0]
                begin
                    lo_reg <= '0;
                    hi_reg <= last_reg;
                    state_reg <= S_TN;
                    if (item_reg.stamp < trd_reg)
                    begin
                        status_reg <= tci_pkg::ST_BEFORE;
                        state_reg  <= S_RD1;
                    end
                end
                S_TN: // trd = t[last]
                begin
                    if (item_reg.stamp >= trd_reg)
                    begin
                        status_reg <= tci_pkg::ST_AFTER;
                        lo_reg     <= last_reg;
                        state_reg  <= S_RD1;
                    end
                    else
                    begin
                        status_reg <= tci_pkg::ST_INTERP;
                        state_reg  <= (hi_reg - lo_reg > IW'(1)) ? S_MID : S_T1;
                    end
                end
                S_MID:
                    state_reg <= S_CMP;
                S_CMP:
                begin
                    if (trd_reg <= item_reg.stamp)
                        lo_reg <= mid;
                    else
                        hi_reg <= mid;
                    status_reg <= status_reg;
                    if (((trd_reg <= item_reg.stamp) ? hi_reg - mid : mid - lo_reg) > IW'(1))
                        state_reg <= S_MID;
                    else
                        state_reg <= S_T1;
                end
                S_T1: // read t[lo]
                begin
                    state_reg <= S_SPAN;
                end
                S_SPAN:
                begin
                    // trd = t[lo]; t[hi] is read now for the span
                    x0_reg    <= trd_reg;
                    state_reg <= S_RD0;
                end
                S_RD0:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (status_reg != tci_pkg::ST_INTERP)
                    begin
                        vals_reg[k_reg] <= crd_reg;
                        state_reg <= S_ANG;
                    end
                    else
                    begin
                        state_reg <= S_WAITD;
                    end
                end
                S_WAITD:
                begin
                    if (drsp.done)
                    begin
                        vals_reg[k_reg] <= neg_reg ? v0_reg - 32'(drsp.quo)
                                                   : v0_reg + 32'(drsp.quo);
                        state_reg <= S_ANG;
                    end
                end
                S_ANG:
                begin
                    prod_reg  <= 64'(amag) * 64'(tci_pkg::DEG2RAD_Q32);
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (k_reg >= CW'(tci_pkg::NUM_COEF - tci_pkg::NUM_ANGLE))
                        vals_reg[k_reg] <= vals_reg[k_reg][31] ? 32'(-rad) : rad;
                    if (k_reg == CW'(tci_pkg::NUM_COEF - 1))
                    begin
                        out_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= (status_reg == tci_pkg::ST_INTERP) ? S_RD0 : S_RD1;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath side registers: span and v0/sign capture.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD0)
            span_reg <= trd_reg - x0_reg;     // t[hi] - t[lo]
        if (state_reg == S_RD1 && status_reg == tci_pkg::ST_INTERP)
            v0_reg <= crd_reg;                // coef[lo]
        if (state_reg == S_DIV)
            neg_reg <= diff[32];
    end

    assign out_data.status       = status_reg;
    assign out_data.out_scale_x  = vals_reg[0];
    assign out_data.out_scale_y  = vals_reg[1];
    assign out_data.out_scale_z  = vals_reg[2];
    assign out_data.out_offset_x = vals_reg[3];
    assign out_data.out_offset_y = vals_reg[4];
    assign out_data.out_offset_z = vals_reg[5];
    assign out_data.out_angle_xy = vals_reg[6];
    assign out_data.out_angle_xz = vals_reg[7];
    assign out_data.out_angle_yz = vals_reg[8];
endmodule
`default_nettype wire

[rtl/tci_checker.sv]
`default_nettype none
module tci_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire tci_pkg::out_item_t out_data
);
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input open while result pending");
    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready held after beat");
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status != 2'd3)) else $error("bad status");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped under stall");
endmodule

bind timed_calibration_interpolator_core tci_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
`default_nettype wire

[tb/sv/timed_calibration_interpolator_core_tb.sv]
`timescale 1ns / 100ps
module timed_calibration_interpolator_core_tb;
    import tci_pkg::*;

    typedef enum int {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_t;
    typedef struct {
        row_kind_t  kind;
        in_item_t   item;
        logic [10:0] cfg;
        bit         has_status;
        logic [1:0] status;
    } row_t;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 3000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic [10:0] cfg_data;

    timed_calibration_interpolator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // shadow of the calibration table and the register
    logic [31:0] cal_time [TABLE_DEPTH];
    logic [31:0] cal_coef [TABLE_DEPTH][NUM_COEF];
    logic [10:0] cal_entries;

    out_item_t   pending_cal[$];
    int          mismatches;
    int          results_seen;
    int          queries_sent;
    int          loads_sent;
    int          send_idle_pct;
    int          take_idle_pct;
    bit          hold_req;
    row_t        directed[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint signed lerp_value(longint signed v0, longint signed v1,
                                                 logic [31:0] num, logic [31:0] den);
        longint signed d;
        logic [63:0] mag;
        logic [63:0] q;
        d = v1 - v0;
        mag = (d < 0) ? -d : d;
        q = (mag * {32'd0, num}) / {32'd0, den};
        return (d < 0) ? v0 - longint'(q) : v0 + longint'(q);
    endfunction

    function automatic logic [31:0] deg_to_rad(logic [31:0] deg);
        longint signed v;
        logic [63:0] mag;
        logic [63:0] r;
        v = longint'($signed(deg));
        mag = (v < 0) ? -v : v;
        r = (mag * {32'd0, DEG2RAD_Q32} + 64'h8000_0000) >> 32;
        return (v < 0) ? -r[31:0] : r[31:0];
    endfunction

    function automatic out_item_t calc_calibration(logic [31:0] x);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic [31:0] vals[NUM_COEF];
        out_item_t r;
        n = 32'(cal_entries);
        if (n < 1) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        if (x < cal_time[0])
        begin
            r.status = ST_BEFORE;
            for (int k = 0; k < NUM_COEF; k++) vals[k] = cal_coef[0][k];
        end
        else if (x >= cal_time[n - 1])
        begin
            r.status = ST_AFTER;
            for (int k = 0; k < NUM_COEF; k++) vals[k] = cal_coef[n - 1][k];
        end
        else
        begin
            r.status = ST_INTERP;
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1)
            begin
                mid = lo + (hi - lo) / 2;
                if (cal_time[mid] <= x) lo = mid;
                else hi = mid;
            end
            for (int k = 0; k < NUM_COEF; k++)
                vals[k] = 32'(lerp_value(longint'($signed(cal_coef[lo][k])),
                                         longint'($signed(cal_coef[hi][k])),
                                         x - cal_time[lo], cal_time[hi] - cal_time[lo]));
        end
        for (int k = NUM_COEF - NUM_ANGLE; k < NUM_COEF; k++) vals[k] = deg_to_rad(vals[k]);
        r.out_scale_x  = vals[0];
        r.out_scale_y  = vals[1];
        r.out_scale_z  = vals[2];
        r.out_offset_x = vals[3];
        r.out_offset_y = vals[4];
        r.out_offset_z = vals[5];
        r.out_angle_xy = vals[6];
        r.out_angle_xz = vals[7];
        r.out_angle_yz = vals[8];
        return r;
    endfunction

    function automatic in_item_t make_item(logic op, logic [9:0] idx, logic [31:0] stamp,
                                           logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                                           logic [31:0] c3, logic [31:0] c4, logic [31:0] c5,
                                           logic [31:0] c6, logic [31:0] c7, logic [31:0] c8);
        in_item_t it;
        it.op = op;
        it.entry_index = idx;
        it.stamp = stamp;
        it.scale_x = c0;  it.scale_y = c1;  it.scale_z = c2;
        it.offset_x = c3; it.offset_y = c4; it.offset_z = c5;
        it.angle_xy = c6; it.angle_xz = c7; it.angle_yz = c8;
        return it;
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(200)) - 100) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t rand_entry(logic [9:0] idx, logic [31:0] stamp);
        return make_item(OP_LOAD, idx, stamp, rand_coef(), rand_coef(), rand_coef(),
                         rand_coef(), rand_coef(), rand_coef(),
                         rand_coef(), rand_coef(), rand_coef());
    endfunction

    // apply an accepted load to the shadow table, queue the expected result of a query
    function automatic void note_beat(in_item_t it);
        if (it.op == OP_LOAD)
        begin
            loads_sent++;
            cal_time[it.entry_index] = it.stamp;
            cal_coef[it.entry_index][0] = it.scale_x;
            cal_coef[it.entry_index][1] = it.scale_y;
            cal_coef[it.entry_index][2] = it.scale_z;
            cal_coef[it.entry_index][3] = it.offset_x;
            cal_coef[it.entry_index][4] = it.offset_y;
            cal_coef[it.entry_index][5] = it.offset_z;
            cal_coef[it.entry_index][6] = it.angle_xy;
            cal_coef[it.entry_index][7] = it.angle_xz;
            cal_coef[it.entry_index][8] = it.angle_yz;
        end
        else
        begin
            queries_sent++;
            pending_cal.push_back(calc_calibration(it.stamp));
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_beat(in_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        note_beat(it);
    endtask

    task automatic drop_valid_and_settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_cal.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_entries(logic [10:0] v);
        drop_valid_and_settle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cal_entries = v;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cal.size() == 0)
            begin
                report_mismatch("unexpected result beat", 32'(out_data.status), 32'd0);
            end
            else
            begin
                out_item_t want;
                want = pending_cal.pop_front();
                results_seen++;
                if (out_data.status != want.status)
                    report_mismatch("status", 32'(out_data.status), 32'(want.status));
                if (out_data.out_scale_x != want.out_scale_x)
                    report_mismatch("scale_x", out_data.out_scale_x, want.out_scale_x);
                if (out_data.out_scale_y != want.out_scale_y)
                    report_mismatch("scale_y", out_data.out_scale_y, want.out_scale_y);
                if (out_data.out_scale_z != want.out_scale_z)
                    report_mismatch("scale_z", out_data.out_scale_z, want.out_scale_z);
                if (out_data.out_offset_x != want.out_offset_x)
                    report_mismatch("offset_x", out_data.out_offset_x, want.out_offset_x);
                if (out_data.out_offset_y != want.out_offset_y)
                    report_mismatch("offset_y", out_data.out_offset_y, want.out_offset_y);
                if (out_data.out_offset_z != want.out_offset_z)
                    report_mismatch("offset_z", out_data.out_offset_z, want.out_offset_z);
                if (out_data.out_angle_xy != want.out_angle_xy)
                    report_mismatch("angle_xy", out_data.out_angle_xy, want.out_angle_xy);
                if (out_data.out_angle_xz != want.out_angle_xz)
                    report_mismatch("angle_xz", out_data.out_angle_xz, want.out_angle_xz);
                if (out_data.out_angle_yz != want.out_angle_yz)
                    report_mismatch("angle_yz", out_data.out_angle_yz, want.out_angle_yz);
            end
        end
    end

    task automatic add_row(row_kind_t kind, in_item_t it, logic [10:0] cfg,
                           bit has_status, logic [1:0] status);
        row_t r;
        r.kind = kind;
        r.item = it;
        r.cfg = cfg;
        r.has_status = has_status;
        r.status = status;
        directed.push_back(r);
    endtask

    task automatic add_query(logic [31:0] t, logic [1:0] status);
        add_row(ROW_QUERY, make_item(OP_QUERY, 10'h3ff, t, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom),
                11'd0, 1'b1, status);
    endtask

    task automatic build_directed();
        in_item_t none;
        none = '0;
        add_row(ROW_LOAD, make_item(OP_LOAD, 10'd0, 32'd100, 32'h8000_0000, 32'h7fff_ffff,
                32'h0, 32'hffff_ffff, 32'h1, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff,
                32'hfffe_8000), 11'd0, 1'b0, ST_BEFORE);
        add_query(32'd0, ST_BEFORE);
        add_query(32'd99, ST_BEFORE);
        add_query(32'd100, ST_AFTER);
        add_query(32'hffff_ffff, ST_AFTER);
        add_row(ROW_CFG, none, 11'd3, 1'b0, ST_BEFORE);
        add_row(ROW_LOAD, make_item(OP_LOAD, 10'd1, 32'd200, 32'h7fff_ffff, 32'h8000_0000,
                32'h0001_0000, 32'h0, 32'hffff_0000, 32'hedcb_a988, 32'h7fff_ffff,
                32'h8000_0000, 32'h0001_8000), 11'd0, 1'b0, ST_BEFORE);
        // equal adjacent times: the pair is never bracketed
        add_row(ROW_LOAD, make_item(OP_LOAD, 10'd2, 32'd200, 32'h0, 32'h0, 32'h0,
                32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 11'd0, 1'b0, ST_BEFORE);
        add_query(32'd100, ST_INTERP);
        add_query(32'd150, ST_INTERP);
        add_query(32'd199, ST_INTERP);
        add_query(32'd200, ST_AFTER);
        add_row(ROW_CFG, none, 11'd0, 1'b0, ST_BEFORE);
        add_query(32'd150, ST_AFTER);
        add_query(32'd50, ST_BEFORE);
        // widest span
        add_row(ROW_CFG, none, 11'd2, 1'b0, ST_BEFORE);
        add_row(ROW_LOAD, make_item(OP_LOAD, 10'd0, 32'd0, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000), 11'd0, 1'b0, ST_BEFORE);
        add_row(ROW_LOAD, make_item(OP_LOAD, 10'd1, 32'hffff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), 11'd0, 1'b0, ST_BEFORE);
        add_query(32'h0, ST_INTERP);
        add_query(32'h7fff_ffff, ST_INTERP);
        add_query(32'hffff_fffe, ST_INTERP);
        add_query(32'hffff_ffff, ST_AFTER);
    endtask

    task automatic run_phase(logic [10:0] reg_value, bit refill, bit sorted, int items);
        int unsigned n;
        logic [31:0] t;
        logic [31:0] q;
        write_entries(reg_value);
        n = (reg_value < 1) ? 1 : (reg_value > TABLE_DEPTH) ? TABLE_DEPTH : reg_value;
        if (refill)
        begin
            t = $urandom_range(1000);
            for (int unsigned s = 0; s < n; s++)
            begin
                send_beat(rand_entry(10'(s), t));
                if (sorted) t = t + $urandom_range(4) * $urandom_range(1 << 20);
                else t = $urandom;
            end
        end
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2 && reg_value == 11'd64) hold_req = 1'b1;
            if ($urandom_range(99) < 25)
            begin
                t = (sorted && $urandom_range(1)) ? cal_time[$urandom_range(n - 1)] : $urandom;
                send_beat(rand_entry(10'($urandom_range(n - 1)), t));
            end
            else
            begin
                case ($urandom_range(5))
                    0: q = $urandom;
                    1: q = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
                    2: q = cal_time[$urandom_range(n - 1)];
                    default: q = cal_time[$urandom_range(n - 1)] + $urandom_range(1 << 21);
                endcase
                send_beat(make_item(OP_QUERY, 10'($urandom), q, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = 11'd0;
        hold_req = 1'b0;
        mismatches = 0;
        results_seen = 0;
        queries_sent = 0;
        loads_sent = 0;
        cal_entries = 11'd1;
        for (int s = 0; s < TABLE_DEPTH; s++)
        begin
            cal_time[s] = '0;
            for (int k = 0; k < NUM_COEF; k++) cal_coef[s][k] = '0;
        end
        send_idle_pct = 18;
        take_idle_pct = 56;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_directed();
        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_entries(directed[i].cfg);
            else
            begin
                send_beat(directed[i].item);
                if (directed[i].has_status && pending_cal[$].status != directed[i].status)
                    report_mismatch("directed status", 32'(pending_cal[$].status),
                                    32'(directed[i].status));
            end
        end

        run_phase(11'd2, 1'b1, 1'b1, 70);
        run_phase(11'd7, 1'b1, 1'b0, 70);
        send_idle_pct = 56;
        take_idle_pct = 18;
        run_phase(11'd64, 1'b1, 1'b1, 80);
        run_phase(11'd1024, 1'b1, 1'b1, 70);
        send_idle_pct = 0;
        take_idle_pct = 0;
        run_phase(11'd2047, 1'b0, 1'b1, 80);
        run_phase(11'd33, 1'b1, 1'b1, 80);

        drop_valid_and_settle();
        $display("covered %0d loads and %0d queries, %0d results checked",
                 loads_sent, queries_sent, results_seen);
        $display("table sizes 0..2047 incl. clamps, sorted and unsorted tables, long stall");
        if (mismatches == 0 && pending_cal.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[timed_calibration_interpolator_core.f]
rtl/tci_pkg.sv
rtl/tci_divider.sv
rtl/timed_calibration_interpolator_core.sv
rtl/tci_checker.sv
tb/sv/timed_calibration_interpolator_core_tb.sv
